// ===== rtl/core/cbre_pkg.sv =====
// ----------------------------------------------------------------------------
// cbre_pkg
// shared types and codes of the collision bitmap rectangle engine
// ----------------------------------------------------------------------------
package cbre_pkg;

  // width of coordinates, sizes and window registers
  localparam int DIM_W = 8;
  // width of the configuration write data
  localparam int CFG_W = 8;

  // action codes carried by an item
  typedef enum logic [1:0] {
    ACT_SET   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_TEST  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // configuration register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t REG_MASK_WIDTH  = 1'b0;
  localparam cfg_idx_t REG_MASK_HEIGHT = 1'b1;

  // window registers after reset
  localparam logic [DIM_W-1:0] MASK_WIDTH_RST  = 8'd128;
  localparam logic [DIM_W-1:0] MASK_HEIGHT_RST = 8'd128;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    S_CLR   = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SETUP = 8'b0000_0100,
    S_ROW   = 8'b0000_1000,
    S_ROW2  = 8'b0001_0000,
    S_TRD   = 8'b0010_0000,
    S_TBIT  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

endpackage

// ===== rtl/core/collision_bitmap_rect_engine_core.sv =====
// ----------------------------------------------------------------------------
// collision_bitmap_rect_engine_core
// one-bit-per-cell collision mask with rectangle set, clear and point test
// ----------------------------------------------------------------------------
// The mask holds MAX_WIDTH x MAX_HEIGHT cells; cell (x, y) of the window in use
// lives at linear address y * W + x, W being mask_width limited to MAX_WIDTH.
// A set or clear item walks the clipped rectangle one row per cycle through a
// single write port of the word store, a row whose span crosses a store word
// boundary taking a second write state. The item is accepted, set up, walked
// row by row, and then its result is handed over. A point test inside the
// window passes through accept, setup, word read, bit pick and result. A point
// outside the window, an empty or fully clipped rectangle and the unused action
// code go from setup straight to the result. The hand-over step repeats for as
// long as the previous result still waits in the output register. After reset
// the store is swept to zero, one word per cycle, over all DEPTH words; no item
// is taken meanwhile, though configuration writes are.
// Window registers are to be written only while the block is idle. Stored bits
// are not moved when the window width changes.
// ----------------------------------------------------------------------------
module collision_bitmap_rect_engine_core #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write port
  input  logic                       cfg_we_i,
  input  cbre_pkg::cfg_idx_t         cfg_idx_i,
  input  logic [cbre_pkg::CFG_W-1:0] cfg_wdata_i,
  // input items
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 action_i,
  input  logic [cbre_pkg::DIM_W-1:0] pos_x_i,
  input  logic [cbre_pkg::DIM_W-1:0] pos_y_i,
  input  logic [cbre_pkg::DIM_W-1:0] size_w_i,
  input  logic [cbre_pkg::DIM_W-1:0] size_h_i,
  // result items
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       hit_o
);

  import cbre_pkg::*;

  // store geometry: words at least one row wide, a power of two
  localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
  localparam int OFF_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WORD_W     = 1 << OFF_W;
  localparam int DEPTH      = (CELL_COUNT + WORD_W - 1) / WORD_W;
  localparam int WADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AW         = OFF_W + WADDR_W;

  // window registers
  logic [DIM_W-1:0] mask_width_q;
  logic [DIM_W-1:0] mask_height_q;
  logic [DIM_W-1:0] wd;
  logic [DIM_W-1:0] ht;

  // sequencer
  state_e state_q, state_d;
  logic [WADDR_W-1:0] clr_q;

  // item registers
  action_e          act_q;
  logic [DIM_W-1:0] px_q;
  logic [DIM_W-1:0] py_q;
  logic [DIM_W-1:0] sw_q;
  logic [DIM_W-1:0] sh_q;

  // walk registers
  logic [AW-1:0]    base_q;
  logic [DIM_W-1:0] row_q;
  logic [DIM_W-1:0] x_end_q;
  logic [DIM_W-1:0] y_end_q;
  logic [OFF_W-1:0] off_q;
  logic             hit_q;

  // output register
  logic out_valid_q;
  logic hit_out_q;

  // setup arithmetic
  logic [DIM_W:0]     x_sum;
  logic [DIM_W:0]     y_sum;
  logic [DIM_W-1:0]   x_end_d;
  logic [DIM_W-1:0]   y_end_d;
  logic [2*DIM_W-1:0] prod;
  logic [DIM_W-1:0]   row_next;
  logic               row_adv;
  logic               in_acc;
  logic               out_free;

  // store and span unit
  logic               ram_we;
  logic [WADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0]  ram_wmask;
  logic               ram_wdata;
  logic               ram_re;
  logic [WORD_W-1:0]  ram_rdata;
  logic [WADDR_W-1:0] first_addr;
  logic [WADDR_W-1:0] last_addr;
  logic [WORD_W-1:0]  first_mask;
  logic [WORD_W-1:0]  last_mask;
  logic               split;
  logic [OFF_W-1:0]   bit_off;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_width_q  <= MASK_WIDTH_RST;
      mask_height_q <= MASK_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MASK_WIDTH:  mask_width_q  <= cfg_wdata_i;
        REG_MASK_HEIGHT: mask_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective window, saturated to the store size
  assign wd = (int'(mask_width_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : mask_width_q;
  assign ht = (int'(mask_height_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : mask_height_q;

  // ---------------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------------
  // setup: clip the rectangle and form the row base y * W
  // ---------------------------------------------------------------------------
  // sums are one bit wider so they never wrap before the clip
  assign x_sum   = {1'b0, px_q} + {1'b0, sw_q};
  assign y_sum   = {1'b0, py_q} + {1'b0, sh_q};
  assign x_end_d = (x_sum > {1'b0, wd}) ? wd : x_sum[DIM_W-1:0];
  assign y_end_d = (y_sum > {1'b0, ht}) ? ht : y_sum[DIM_W-1:0];
  assign prod    = {{DIM_W{1'b0}}, py_q} * {{DIM_W{1'b0}}, wd};

  // row y always stays below the clipped end, so the increment never wraps
  assign row_next = row_q + DIM_W'(1);

  // ---------------------------------------------------------------------------
  // span unit: row span to store words and bit masks
  // ---------------------------------------------------------------------------
  cbre_seg_unit #(
    .OFF_W   (OFF_W),
    .WADDR_W (WADDR_W)
  ) u_seg (
    .base_i       (base_q),
    .x_lo_i       (px_q),
    .x_hi_i       (x_end_q),
    .first_addr_o (first_addr),
    .last_addr_o  (last_addr),
    .first_mask_o (first_mask),
    .last_mask_o  (last_mask),
    .split_o      (split),
    .bit_off_o    (bit_off)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_waddr = first_addr;
    ram_wmask = first_mask;
    ram_wdata = (act_q == ACT_SET);
    ram_re    = 1'b0;
    row_adv   = 1'b0;
    case (state_q)
      S_CLR: begin
        // zero sweep of the whole store after reset
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wmask = {WORD_W{1'b1}};
        ram_wdata = 1'b0;
        if (clr_q == WADDR_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        case (act_q)
          ACT_SET, ACT_CLEAR: begin
            // nothing to do when the clipped rectangle is empty
            if ((px_q < x_end_d) && (py_q < y_end_d)) begin
              state_d = S_ROW;
            end else begin
              state_d = S_DONE;
            end
          end
          ACT_TEST: begin
            // strict bounds on both axes
            if ((px_q < wd) && (py_q < ht)) begin
              state_d = S_TRD;
            end else begin
              state_d = S_DONE;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_ROW: begin
        ram_we = 1'b1;
        if (split) begin
          state_d = S_ROW2;
        end else begin
          row_adv = 1'b1;
        end
      end
      S_ROW2: begin
        // tail of a span that runs into the next word
        ram_we    = 1'b1;
        ram_waddr = last_addr;
        ram_wmask = last_mask;
        row_adv   = 1'b1;
      end
      S_TRD: begin
        ram_re  = 1'b1;
        state_d = S_TBIT;
      end
      S_TBIT: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (row_adv) begin
      state_d = (row_next == y_end_q) ? S_DONE : S_ROW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) begin
        clr_q <= clr_q + WADDR_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // item and walk registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q <= action_e'(action_i);
      px_q  <= pos_x_i;
      py_q  <= pos_y_i;
      sw_q  <= size_w_i;
      sh_q  <= size_h_i;
    end
    if (state_q == S_SETUP) begin
      base_q  <= AW'(prod);
      row_q   <= py_q;
      x_end_q <= x_end_d;
      y_end_q <= y_end_d;
      hit_q   <= 1'b0;
    end
    if (row_adv) begin
      row_q  <= row_next;
      base_q <= base_q + AW'(wd);
    end
    if (state_q == S_TRD) begin
      off_q <= bit_off;
    end
    if (state_q == S_TBIT) begin
      hit_q <= ram_rdata[off_q];
    end
  end

  // ---------------------------------------------------------------------------
  // mask store
  // ---------------------------------------------------------------------------
  cbre_mask_ram #(
    .WORD_W (WORD_W),
    .DEPTH  (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wmask_i (ram_wmask),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (first_addr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // output register: a waiting result does not hold up the next item
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_DONE) && out_free) begin
      hit_out_q <= hit_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_acc_to_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_SETUP))
    else $error("accepted item did not start setup");

  a_no_write_in_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_TRD) || (state_q == S_TBIT) || (state_q == S_IDLE)) |-> !ram_we)
    else $error("store written outside sweep or rectangle walk");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_ROW) || (state_q == S_ROW2)) |-> (row_q < y_end_q))
    else $error("row walk past clipped end");

  a_tail_after_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROW2) |-> (split && ($past(state_q) == S_ROW)))
    else $error("second word written without a split span");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(hit_out_q)))
    else $error("pending result overwritten");

endmodule

// ===== rtl/core/cbre_mask_ram.sv =====
// ----------------------------------------------------------------------------
// cbre_mask_ram
// word-wide mask store with per-bit write enable and registered read
// ----------------------------------------------------------------------------
module cbre_mask_ram #(
  parameter int WORD_W = 128,
  parameter int DEPTH  = 128,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WORD_W-1:0] wmask_i,
  input  logic              wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  // every selected bit of the word takes the same fill value
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int i = 0; i < WORD_W; i++) begin
        if (wmask_i[i]) begin
          mem_q[waddr_i][i] <= wdata_i;
        end
      end
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/cbre_seg_unit.sv =====
// ----------------------------------------------------------------------------
// cbre_seg_unit
// maps one row span of linear cell addresses onto store words and bit masks
// ----------------------------------------------------------------------------
module cbre_seg_unit #(
  parameter int OFF_W   = 7,
  parameter int WADDR_W = 7
) (
  input  logic [OFF_W+WADDR_W-1:0]   base_i,
  input  logic [cbre_pkg::DIM_W-1:0] x_lo_i,
  input  logic [cbre_pkg::DIM_W-1:0] x_hi_i,
  output logic [WADDR_W-1:0]         first_addr_o,
  output logic [WADDR_W-1:0]         last_addr_o,
  output logic [(1<<OFF_W)-1:0]      first_mask_o,
  output logic [(1<<OFF_W)-1:0]      last_mask_o,
  output logic                       split_o,
  output logic [OFF_W-1:0]           bit_off_o
);

  localparam int AW     = OFF_W + WADDR_W;
  localparam int WORD_W = 1 << OFF_W;

  logic [AW-1:0]     start_a;
  logic [AW-1:0]     end_a;
  logic [OFF_W-1:0]  end_off;
  logic [WORD_W-1:0] lo_mask;
  logic [WORD_W-1:0] hi_mask;

  // first cell and last cell (inclusive) of the span
  assign start_a = base_i + AW'(x_lo_i);
  assign end_a   = base_i + AW'(x_hi_i) - AW'(1);

  assign bit_off_o    = start_a[OFF_W-1:0];
  assign end_off      = end_a[OFF_W-1:0];
  assign first_addr_o = start_a[AW-1:OFF_W];
  assign last_addr_o  = end_a[AW-1:OFF_W];

  // a span is never longer than a word, so it touches at most two words
  assign split_o = (first_addr_o != last_addr_o);

  assign lo_mask = {WORD_W{1'b1}} << bit_off_o;
  assign hi_mask = {WORD_W{1'b1}} >> (OFF_W'(WORD_W - 1) - end_off);

  assign first_mask_o = split_o ? lo_mask : (lo_mask & hi_mask);
  assign last_mask_o  = hi_mask;

endmodule
